FILE: rtl/mprq_pkg.sv
// ----------------------------------------------------------------------------
// mprq_pkg
// shared types for the multilevel priority ring queue: transaction payloads,
// commands, sequencer states, datapath operations and the control structs
// ----------------------------------------------------------------------------
package mprq_pkg;

  localparam int unsigned VALUE_W = 8;
  localparam int unsigned LEVEL_W = 2;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_REM  = 2'd2,
    CMD_MOVE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] dest_level;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] front_value;
    logic               front_valid;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_FRONT_RD,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ENQ,
    OP_DEQ,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_SHRINK,
    OP_APPEND,
    OP_FRONT_RD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   set_fail;
    logic   in_ready;
    logic   load_res;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic lvl_bad;
    logic dst_bad;
    logic full;
    logic empty;
    logic scan_end;
    logic match;
    logic shift_more;
  } stat_t;

endpackage

FILE: rtl/mprq_dp.sv
// ----------------------------------------------------------------------------
// mprq_dp
// entry memory, per-level head and count tables, scan pointers and the
// shared wrap-around adder used by the enqueue, dequeue, append, scan and shift steps
// ----------------------------------------------------------------------------
module mprq_dp #(
  parameter int unsigned NUM_LEVELS = 4,
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mprq_pkg::in_item_t  in_item_i,
  input  mprq_pkg::ctrl_t     ctrl_i,
  output mprq_pkg::stat_t     stat_o,
  output mprq_pkg::out_item_t res_o
);
  import mprq_pkg::*;

  localparam int unsigned LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned PW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned AW  = (NUM_LEVELS * DEPTH > 1) ? $clog2(NUM_LEVELS * DEPTH) : 1;
  localparam int unsigned AXW = AW + 1;
  localparam int unsigned SIZE = NUM_LEVELS * DEPTH;

  cmd_e                  cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [LEVEL_W-1:0]    lvl_q, lvl_d;
  logic [LEVEL_W-1:0]    dst_q, dst_d;
  logic [PW-1:0]         head_q [NUM_LEVELS];
  logic [PW-1:0]         head_d [NUM_LEVELS];
  logic [CW-1:0]         cnt_q  [NUM_LEVELS];
  logic [CW-1:0]         cnt_d  [NUM_LEVELS];
  logic [CW-1:0]         total_q, total_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic                  fail_q, fail_d;

  logic [DATA_WIDTH-1:0] mem_q [SIZE];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;

  logic [LW+LEVEL_W-1:0] lvl_ext, dst_ext;
  logic [LW-1:0]         lvl_ix, dst_ix, front_ix;
  logic                  any;

  logic [PW-1:0]         add_a;
  logic [CW-1:0]         add_b;
  logic [SW-1:0]         add_sum;
  logic [PW-1:0]         add_r;

  logic [VALUE_W+DATA_WIDTH-1:0] val_ext;
  logic [VALUE_W+DATA_WIDTH-1:0] front_ext;

  function automatic logic [AW-1:0] slot_addr(logic [LW-1:0] l, logic [PW-1:0] p);
    logic [AXW-1:0] a;
    a = AXW'(l) * AXW'(DEPTH) + AXW'(p);
    return a[AW-1:0];
  endfunction

  assign lvl_ext = {{LW{1'b0}}, lvl_q};
  assign dst_ext = {{LW{1'b0}}, dst_q};
  assign lvl_ix  = lvl_ext[LW-1:0];
  assign dst_ix  = dst_ext[LW-1:0];
  assign any     = (total_q != '0);

  // lowest non-empty level
  always_comb begin
    front_ix = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        front_ix = LW'(i);
      end
    end
  end

  // shared wrap-around adder
  always_comb begin
    unique case (ctrl_i.op)
      OP_ENQ: begin
        add_a = head_q[lvl_ix];
        add_b = cnt_q[lvl_ix];
      end
      OP_APPEND: begin
        add_a = head_q[dst_ix];
        add_b = cnt_q[dst_ix];
      end
      OP_DEQ: begin
        add_a = head_q[front_ix];
        add_b = CW'(1);
      end
      default: begin
        add_a = pos_q;
        add_b = CW'(1);
      end
    endcase
    add_sum = SW'(add_a) + SW'(add_b);
    if (add_sum >= SW'(DEPTH)) begin
      add_sum = add_sum - SW'(DEPTH);
    end
    add_r = add_sum[PW-1:0];
  end

  assign val_ext = {{DATA_WIDTH{1'b0}}, in_item_i.value};

  // register updates
  always_comb begin
    cmd_d   = cmd_q;
    val_d   = val_q;
    lvl_d   = lvl_q;
    dst_d   = dst_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    fail_d  = fail_q;
    unique case (ctrl_i.op)
      OP_LATCH: begin
        cmd_d  = in_item_i.command;
        val_d  = val_ext[DATA_WIDTH-1:0];
        lvl_d  = in_item_i.level;
        dst_d  = in_item_i.dest_level;
        fail_d = 1'b0;
      end
      OP_ENQ: begin
        cnt_d[lvl_ix] = cnt_q[lvl_ix] + CW'(1);
        total_d       = total_q + CW'(1);
      end
      OP_APPEND: begin
        cnt_d[dst_ix] = cnt_q[dst_ix] + CW'(1);
        total_d       = total_q + CW'(1);
      end
      OP_DEQ: begin
        cnt_d[front_ix]  = cnt_q[front_ix] - CW'(1);
        head_d[front_ix] = add_r;
        total_d          = total_q - CW'(1);
      end
      OP_SCAN_INIT: begin
        idx_d = '0;
        pos_d = head_q[lvl_ix];
      end
      OP_SCAN_NEXT, OP_SHIFT_WR: begin
        idx_d = idx_q + CW'(1);
        pos_d = add_r;
      end
      OP_SHRINK: begin
        cnt_d[lvl_ix] = cnt_q[lvl_ix] - CW'(1);
        total_d       = total_q - CW'(1);
      end
      OP_NONE, OP_SCAN_RD, OP_SHIFT_RD, OP_FRONT_RD: ;
      default: ;
    endcase
    if (ctrl_i.set_fail) begin
      fail_d = 1'b1;
    end
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = slot_addr(lvl_ix, pos_q);
    raddr = slot_addr(lvl_ix, pos_q);
    wdata = val_q;
    unique case (ctrl_i.op)
      OP_ENQ: begin
        we    = 1'b1;
        waddr = slot_addr(lvl_ix, add_r);
      end
      OP_APPEND: begin
        we    = 1'b1;
        waddr = slot_addr(dst_ix, add_r);
      end
      OP_SHIFT_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      OP_SCAN_RD: begin
        re = 1'b1;
      end
      OP_SHIFT_RD: begin
        re    = 1'b1;
        raddr = slot_addr(lvl_ix, add_r);
      end
      OP_FRONT_RD: begin
        re    = 1'b1;
        raddr = slot_addr(front_ix, head_q[front_ix]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      total_q <= '0;
      fail_q  <= 1'b0;
      cmd_q   <= CMD_ENQ;
    end else begin
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      fail_q  <= fail_d;
      cmd_q   <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    lvl_q <= lvl_d;
    dst_q <= dst_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.lvl_bad    = (int'(lvl_q) >= NUM_LEVELS);
  assign stat_o.dst_bad    = (int'(dst_q) >= NUM_LEVELS);
  assign stat_o.full       = (total_q >= CW'(DEPTH)) || (cnt_q[lvl_ix] >= CW'(DEPTH));
  assign stat_o.empty      = !any;
  assign stat_o.scan_end   = (idx_q == cnt_q[lvl_ix]);
  assign stat_o.match      = (rdata_q == val_q);
  assign stat_o.shift_more = ((idx_q + CW'(1)) < cnt_q[lvl_ix]);

  assign front_ext         = {{VALUE_W{1'b0}}, rdata_q};
  assign res_o.status      = fail_q;
  assign res_o.front_valid = any;
  assign res_o.front_value = any ? front_ext[VALUE_W-1:0] : '0;

endmodule

FILE: rtl/mprq_ctrl.sv
// ----------------------------------------------------------------------------
// mprq_ctrl
// sequencer that steps the datapath through one command at a time
// ----------------------------------------------------------------------------
module mprq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            res_free_i,
  input  mprq_pkg::stat_t stat_i,
  output mprq_pkg::ctrl_t ctrl_o
);
  import mprq_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (stat_i.cmd)
          CMD_ENQ, CMD_DEQ: state_d = ST_FRONT_RD;
          CMD_REM:  state_d = stat_i.lvl_bad ? ST_FRONT_RD : ST_SCAN_RD;
          CMD_MOVE: state_d = (stat_i.lvl_bad || stat_i.dst_bad) ? ST_FRONT_RD : ST_SCAN_RD;
          default:  state_d = ST_FRONT_RD;
        endcase
      end
      ST_SCAN_RD: begin
        state_d = stat_i.scan_end ? ST_FRONT_RD : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        state_d = stat_i.match ? ST_SHIFT_RD : ST_SCAN_RD;
      end
      ST_SHIFT_RD: begin
        if (stat_i.shift_more) begin
          state_d = ST_SHIFT_WR;
        end else begin
          state_d = (stat_i.cmd == CMD_MOVE) ? ST_APPEND : ST_FRONT_RD;
        end
      end
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_APPEND:   state_d = ST_FRONT_RD;
      ST_FRONT_RD: state_d = ST_DONE;
      ST_DONE: begin
        if (res_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '{op: OP_NONE, set_fail: 1'b0, in_ready: 1'b0, load_res: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) ctrl_o.op = OP_LATCH;
      end
      ST_EXEC: begin
        unique case (stat_i.cmd)
          CMD_ENQ: begin
            if (stat_i.lvl_bad || stat_i.full) ctrl_o.set_fail = 1'b1;
            else ctrl_o.op = OP_ENQ;
          end
          CMD_DEQ: begin
            if (stat_i.empty) ctrl_o.set_fail = 1'b1;
            else ctrl_o.op = OP_DEQ;
          end
          CMD_REM: begin
            if (stat_i.lvl_bad) ctrl_o.set_fail = 1'b1;
            else ctrl_o.op = OP_SCAN_INIT;
          end
          CMD_MOVE: begin
            if (stat_i.lvl_bad || stat_i.dst_bad) ctrl_o.set_fail = 1'b1;
            else ctrl_o.op = OP_SCAN_INIT;
          end
          default: ctrl_o.set_fail = 1'b1;
        endcase
      end
      ST_SCAN_RD: begin
        if (stat_i.scan_end) ctrl_o.set_fail = 1'b1;
        else ctrl_o.op = OP_SCAN_RD;
      end
      ST_SCAN_CMP: begin
        if (!stat_i.match) ctrl_o.op = OP_SCAN_NEXT;
      end
      ST_SHIFT_RD: begin
        ctrl_o.op = stat_i.shift_more ? OP_SHIFT_RD : OP_SHRINK;
      end
      ST_SHIFT_WR: ctrl_o.op = OP_SHIFT_WR;
      ST_APPEND:   ctrl_o.op = OP_APPEND;
      ST_FRONT_RD: ctrl_o.op = OP_FRONT_RD;
      ST_DONE:     ctrl_o.load_res = res_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/multilevel_priority_ring_queue.sv
// ----------------------------------------------------------------------------
// multilevel_priority_ring_queue
// priority queue with one ring region per level and a shared occupancy cap
// ----------------------------------------------------------------------------
// in channel (in_valid_i / in_ready_o / in_item_i) carries a command:
// enqueue, dequeue, remove or move. out channel (out_valid_o / out_ready_i /
// out_item_o) returns one transaction per command: status, and the head of
// the lowest non-empty level with its valid flag.
// one command is processed at a time by a sequencer around a single
// wrap-around adder and a one-write, one-read entry memory.
// enqueue and dequeue: the command is latched and executed, and the head is
// read before the result is loaded.
// remove and move: each entry of the level is read and compared up to the
// match, each later entry is read and shifted forward, the level shrinks, and
// move then appends the value to the destination level before the head read.
// a failed search reads every entry of the level. the sequencer returns to
// idle once the result is loaded and takes the next command there.
// the result sits in an output register, so the next command is accepted
// while an earlier result is still stalled; the sequencer only waits when a
// new result is ready and the output register is still full.
// reset empties all levels; no memory clearing is needed.
// ----------------------------------------------------------------------------
module multilevel_priority_ring_queue #(
  parameter int unsigned NUM_LEVELS = 4,
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mprq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mprq_pkg::out_item_t out_item_o
);
  import mprq_pkg::*;

  ctrl_t     ctrl;
  stat_t     stat;
  out_item_t res;
  out_item_t res_q;
  logic      out_valid_q, out_valid_d;
  logic      res_free;

  assign res_free = !out_valid_q || out_ready_i;

  mprq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .res_free_i (res_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  mprq_dp #(
    .NUM_LEVELS (NUM_LEVELS),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.load_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_res) begin
      res_q <= res;
    end
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

endmodule
